[rtl/core/lsfs_pkg.sv]
package lsfs_pkg;

  localparam int COLOR_W      = 7;
  localparam int BYTE_W       = 8;
  localparam int STRIP_LEN_W  = 11;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  // register index, taken from paddr[2]
  localparam logic REG_STRIP_LENGTH = 1'b0;

  localparam logic [STRIP_LEN_W-1:0] STRIP_LEN_RESET = 11'd1;

  // one pixel request as it travels from front to back
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
  } pixel_t;

endpackage

[rtl/core/lsfs_front.sv]
module lsfs_front
  import lsfs_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [COLOR_W-1:0]                    red,
  input  logic [COLOR_W-1:0]                    green,
  input  logic [COLOR_W-1:0]                    blue,
  input  logic [$clog2(MAX_LEDS+1)-1:0]         len_m1,
  output logic                                  push,
  output pixel_t                                push_pixel
);

  localparam int LEN_W = $clog2(MAX_LEDS + 1);
  localparam int POS_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             is_last;

  // frame closes when the position reaches or passes length minus one
  assign is_last = LEN_W'(pos) >= len_m1;
  assign push    = in_valid && in_ready;

  assign push_pixel = '{red: red, green: green, blue: blue, last: is_last};

  always_comb begin
    pos_next = pos;
    if (push) begin
      if (is_last) begin
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

[rtl/core/lsfs_queue.sv]
module lsfs_queue
  import lsfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pixel_t     push_pixel,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output pixel_t     head
);

  pixel_t      mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2 || $past(pop))
    else $error("queue lost an entry");

endmodule

[rtl/core/lsfs_back.sv]
module lsfs_back
  import lsfs_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          head_valid,
  input  pixel_t                                        head,
  output logic                                          pop,
  input  logic [$clog2((MAX_LEDS+31)/32+1)-1:0]         latch_count,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [BYTE_W-1:0]                             wire_byte,
  output logic                                          frame_end
);

  localparam int LATCH_W = $clog2((MAX_LEDS + 31) / 32 + 1);

  localparam logic [1:0] PH_GREEN = 2'd0;
  localparam logic [1:0] PH_RED   = 2'd1;
  localparam logic [1:0] PH_BLUE  = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  logic [1:0]         phase;
  logic [1:0]         phase_next;
  logic [LATCH_W-1:0] latch_cnt;
  logic [LATCH_W-1:0] latch_cnt_next;
  logic               load;
  logic               issue;
  logic [BYTE_W-1:0]  byte_next;
  logic               end_next;

  // output register takes a byte whenever it is empty or being drained
  assign load  = !out_valid || out_ready;
  assign issue = load && head_valid;

  always_comb begin
    phase_next     = phase;
    latch_cnt_next = latch_cnt;
    byte_next      = '0;
    end_next       = 1'b0;
    pop            = 1'b0;
    case (phase)
      PH_GREEN: begin
        byte_next  = {1'b1, head.green};
        phase_next = PH_RED;
      end
      PH_RED: begin
        byte_next  = {1'b1, head.red};
        phase_next = PH_BLUE;
      end
      PH_BLUE: begin
        byte_next = {1'b1, head.blue};
        if (head.last) begin
          phase_next     = PH_LATCH;
          latch_cnt_next = LATCH_W'(1);
        end else begin
          phase_next = PH_GREEN;
          pop        = issue;
        end
      end
      PH_LATCH: begin
        byte_next = '0;
        if (latch_cnt == latch_count) begin
          end_next   = 1'b1;
          phase_next = PH_GREEN;
          pop        = issue;
        end else begin
          latch_cnt_next = latch_cnt + LATCH_W'(1);
        end
      end
      default: begin
        phase_next = PH_GREEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_GREEN;
      latch_cnt <= LATCH_W'(1);
      out_valid <= 1'b0;
    end else if (issue) begin
      phase     <= phase_next;
      latch_cnt <= latch_cnt_next;
      out_valid <= 1'b1;
    end else if (load) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      wire_byte <= byte_next;
      frame_end <= end_next;
    end
  end

  a_end_is_latch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> wire_byte == '0)
    else $error("frame end on a color byte");

  a_color_msb: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wire_byte != '0) |-> wire_byte[BYTE_W-1])
    else $error("color byte without top bit");

  a_latch_owner: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LATCH) |-> (head_valid && head.last))
    else $error("latch phase without a frame-closing pixel");

  a_latch_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LATCH) |-> (latch_cnt <= latch_count && latch_cnt != '0))
    else $error("latch counter out of range");

endmodule

[rtl/core/led_strip_frame_serializer_unit.sv]
// a taken pixel is written into the queue, then its first wire byte into the output register
// throughput: one wire byte per cycle while out_ready is high and a pixel is queued; a pixel
//   yields 3 bytes, the frame-closing pixel 3 + ceil(L/32), L being the clamped strip length
// a two-entry queue lets up to two pixels be taken ahead of the byte sequencer
// reset (synchronous, active high) clears the pixel position, queue and output valid,
//   and sets strip_length to 1
module led_strip_frame_serializer_unit
  import lsfs_pkg::*;
#(
  parameter int MAX_LEDS = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // pixel requests
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COLOR_W-1:0]     red,
  input  logic [COLOR_W-1:0]     green,
  input  logic [COLOR_W-1:0]     blue,
  // wire bytes
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      wire_byte,
  output logic                   frame_end
);

  localparam int LEN_W   = $clog2(MAX_LEDS + 1);
  localparam int CMP_W   = (LEN_W > STRIP_LEN_W) ? LEN_W : STRIP_LEN_W;
  localparam int LATCH_W = $clog2((MAX_LEDS + 31) / 32 + 1);

  logic [STRIP_LEN_W-1:0] strip_length;
  logic [CMP_W-1:0]       len_wide;
  logic [CMP_W-1:0]       sl_wide;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       len_m1;
  logic [LEN_W:0]         latch_sum;
  logic [LATCH_W-1:0]     latch_count;
  logic                   cfg_write;

  logic                   push;
  pixel_t                 push_pixel;
  logic                   q_full;
  pixel_t                 q_head;
  logic                   q_pop;
  logic                   q_head_valid;

  // register port: always ready, write lands on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= STRIP_LEN_RESET;
    end else if (cfg_write && paddr[2] == REG_STRIP_LENGTH) begin
      strip_length <= pwdata[STRIP_LEN_W-1:0];
    end
  end

  // readback, addresses beyond the register list read zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_STRIP_LENGTH) begin
      prdata = APB_DATA_W'(strip_length);
    end
  end

  // clamp length to 1..MAX_LEDS; zero behaves as one
  assign sl_wide = CMP_W'(strip_length);
  always_comb begin
    if (sl_wide == '0) begin
      len_wide = CMP_W'(1);
    end else if (sl_wide > CMP_W'(MAX_LEDS)) begin
      len_wide = CMP_W'(MAX_LEDS);
    end else begin
      len_wide = sl_wide;
    end
  end
  assign len    = len_wide[LEN_W-1:0];
  assign len_m1 = len - LEN_W'(1);

  // latch bytes: ceil(len / 32)
  assign latch_sum   = (LEN_W+1)'(len) + (LEN_W+1)'(31);
  assign latch_count = LATCH_W'(latch_sum >> 5);

  // front takes a pixel whenever the queue has room
  assign in_ready = !q_full;

  lsfs_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .len_m1     (len_m1),
    .push       (push),
    .push_pixel (push_pixel)
  );

  lsfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pixel (push_pixel),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back walks green, red, blue, then latch bytes on a frame-closing pixel
  lsfs_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head        (q_head),
    .pop         (q_pop),
    .latch_count (latch_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .wire_byte   (wire_byte),
    .frame_end   (frame_end)
  );

endmodule
